/* sv/fragment_reassembly_tracker_defines.svh */
// assertion macros for the fragment reassembly tracker
`ifndef FRAGMENT_REASSEMBLY_TRACKER_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_DEFINES_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define FRT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define FRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/frt_pkg.sv */
// shared types and constants of the fragment reassembly tracker
package frt_pkg;

  localparam int IDX_W = 8;
  localparam int MAP_W = 64;
  localparam int TOT_W = 7;
  localparam int POP_STEPS = MAP_W / 8;

  localparam logic [1:0] STAT_ACCEPT = 2'd0;
  localparam logic [1:0] STAT_DONE   = 2'd1;
  localparam logic [1:0] STAT_DROP   = 2'd2;
  localparam logic [1:0] STAT_STATS  = 2'd3;

  localparam logic MODE_FRAG  = 1'b0;
  localparam logic MODE_STATS = 1'b1;

  localparam logic CFG_FIRST_BYTES = 1'b0;
  localparam logic CFG_DATA_BYTES  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_POP,
    ST_UPDATE
  } state_t;

  // record handed from cell to cell during a table scan
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] m_idx;
    logic [MAP_W-1:0] m_seen;
    logic [TOT_W-1:0] m_total;
    logic [31:0]      m_size;
    logic             have_free;
    logic [IDX_W-1:0] f_idx;
    logic             have_best;
    logic [IDX_W-1:0] b_idx;
    logic [15:0]      b_age;
    logic [MAP_W-1:0] b_seen;
    logic [TOT_W-1:0] b_total;
  } scan_t;

  // slot write broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             valid;
    logic [15:0]      id;
    logic [MAP_W-1:0] seen;
    logic [TOT_W-1:0] total;
    logic [31:0]      size;
    logic             stamp_en;
    logic [15:0]      stamp;
  } wr_t;

endpackage

/* sv/frt_cell.sv */
// one table slot: holds its entry and merges it into the passing scan record
module frt_cell #(
  parameter int CELL_ID = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  frt_pkg::scan_t   cin,
  output frt_pkg::scan_t   cout,
  input  logic [15:0]      mid,
  input  logic [15:0]      ictr,
  input  frt_pkg::wr_t     wr
);

  logic                      valid_r;
  logic [15:0]               id_r;
  logic [frt_pkg::MAP_W-1:0] seen_r;
  logic [frt_pkg::TOT_W-1:0] total_r;
  logic [31:0]               size_r;
  logic [15:0]               stamp_r;
  frt_pkg::scan_t            cout_r;
  frt_pkg::scan_t            cout_nxt;
  logic [15:0]               age;
  logic                      hit;

  assign hit = wr.en && (wr.idx == frt_pkg::IDX_W'(CELL_ID));
  assign age = ictr - stamp_r;

  // merge own entry into the scan record
  always_comb begin
    cout_nxt = cin;
    if (!cin.found && valid_r && (id_r == mid)) begin
      cout_nxt.found   = 1'b1;
      cout_nxt.m_idx   = frt_pkg::IDX_W'(CELL_ID);
      cout_nxt.m_seen  = seen_r;
      cout_nxt.m_total = total_r;
      cout_nxt.m_size  = size_r;
    end
    if (!cin.have_free && !valid_r) begin
      cout_nxt.have_free = 1'b1;
      cout_nxt.f_idx     = frt_pkg::IDX_W'(CELL_ID);
    end
    if (!cin.have_best || (age > cin.b_age)) begin
      cout_nxt.have_best = 1'b1;
      cout_nxt.b_idx     = frt_pkg::IDX_W'(CELL_ID);
      cout_nxt.b_age     = age;
      cout_nxt.b_seen    = seen_r;
      cout_nxt.b_total   = total_r;
    end
  end

  // scan stage register
  always_ff @(posedge clk) begin
    cout_r <= cout_nxt;
  end

  assign cout = cout_r;

  // slot valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (hit) begin
      valid_r <= wr.valid;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (hit) begin
      id_r    <= wr.id;
      seen_r  <= wr.seen;
      total_r <= wr.total;
      size_r  <= wr.size;
      if (wr.stamp_en) begin
        stamp_r <= wr.stamp;
      end
    end
  end

endmodule

/* sv/fragment_reassembly_tracker.sv */
// top level: controller and chain of slot cells
// stats read and dropped fragments: result strobe in the cycle after the transfer
// fragment: result strobe after the scan, resolve and update states, with the pop state between on eviction
// the scan walks the cell chain one cell a cycle; eviction adds an 8-step bit count
// busy is high until the result strobe; no new transfer is taken while busy
// synchronous active-low reset empties all slots and clears counters
`include "fragment_reassembly_tracker_defines.svh"

module fragment_reassembly_tracker #(
  parameter int SLOTS     = 32,
  parameter int MAX_FRAGS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [15:0] in_message_id,
  input  logic [7:0]  in_fragment_index,
  input  logic [7:0]  in_remaining_fragments,
  input  logic [15:0] in_payload_length,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [4:0]  out_slot_index,
  output logic [31:0] out_byte_offset,
  output logic [31:0] out_message_size,
  output logic [6:0]  out_fragment_total,
  output logic        out_evicted,
  output logic [31:0] out_expected_count,
  output logic [31:0] out_missing_count
);

  localparam int MW = frt_pkg::MAP_W;
  localparam int TW = frt_pkg::TOT_W;
  localparam int IW = frt_pkg::IDX_W;

  frt_pkg::state_t state_r, state_nxt;
  frt_pkg::scan_t  chain [SLOTS+1];
  frt_pkg::wr_t    wr;

  logic [15:0] first_bytes_r, data_bytes_r;
  logic [15:0] ictr_r;
  logic [31:0] exp_r, miss_r;
  logic [7:0]  cnt_r;
  logic        accept, drop;
  logic        stats_acc;

  // latched fragment
  logic [15:0] mid_r, plen_r;
  logic [7:0]  fidx_r, rem_r;

  // resolved slot
  logic [IW-1:0] slot_r;
  logic          new_r, ev_r;
  logic [MW-1:0] cur_seen_r, vmask_r;
  logic [TW-1:0] cur_total_r, vt_r, pc_r;
  logic [31:0]   cur_size_r, offset_r;

  // resolve and update datapath
  logic [7:0]    fm1;
  logic [23:0]   prod;
  logic [31:0]   offset_nxt;
  logic [MW-1:0] vmask_nxt, tmask, seen_n;
  logic [8:0]    rp1;
  logic [TW-1:0] t1, t2;
  logic [31:0]   end_byte, size_n;
  logic          complete;
  logic [7:0]    chunk;
  logic [TW-1:0] chunk_cnt;
  logic [31:0]   slot_ext;

  // output registers
  logic        out_valid_r;
  logic [1:0]  status_r;
  logic [4:0]  slot_out_r;
  logic [31:0] boff_r, msize_r, ecnt_r, mcnt_r;
  logic [6:0]  ftot_r;
  logic        evo_r;

  assign accept = start && (state_r == frt_pkg::ST_IDLE);
  assign drop = (in_fragment_index >= 8'(MAX_FRAGS)) ||
                ((in_fragment_index == 8'd0) &&
                 ((9'(in_remaining_fragments) + 9'd1) > 9'(MAX_FRAGS)));
  assign stats_acc = accept && (in_mode == frt_pkg::MODE_STATS);

  // cell chain
  assign chain[0] = '0;
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    frt_cell #(.CELL_ID(g)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .cin  (chain[g]),
      .cout (chain[g+1]),
      .mid  (mid_r),
      .ictr (ictr_r),
      .wr   (wr)
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      frt_pkg::ST_IDLE: begin
        if (accept && (in_mode == frt_pkg::MODE_FRAG) && !drop) begin
          state_nxt = frt_pkg::ST_SCAN;
        end
      end
      frt_pkg::ST_SCAN: begin
        if (cnt_r == 8'(SLOTS - 1)) begin
          state_nxt = frt_pkg::ST_RESOLVE;
        end
      end
      frt_pkg::ST_RESOLVE: begin
        if (chain[SLOTS].found || chain[SLOTS].have_free) begin
          state_nxt = frt_pkg::ST_UPDATE;
        end else begin
          state_nxt = frt_pkg::ST_POP;
        end
      end
      frt_pkg::ST_POP: begin
        if (cnt_r == 8'(frt_pkg::POP_STEPS - 1)) begin
          state_nxt = frt_pkg::ST_UPDATE;
        end
      end
      frt_pkg::ST_UPDATE: state_nxt = frt_pkg::ST_IDLE;
      default:            state_nxt = frt_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy        = (state_r != frt_pkg::ST_IDLE);
    wr.en       = (state_r == frt_pkg::ST_UPDATE);
    wr.idx      = slot_r;
    wr.valid    = !complete;
    wr.id       = mid_r;
    wr.seen     = seen_n;
    wr.total    = t2;
    wr.size     = size_n;
    wr.stamp_en = new_r;
    wr.stamp    = ictr_r;
  end

  // offset and victim mask at resolve
  always_comb begin
    fm1        = fidx_r - 8'd1;
    prod       = 24'(fm1) * 24'(data_bytes_r);
    offset_nxt = (fidx_r == 8'd0) ? 32'd0 : (32'(first_bytes_r) + 32'(prod));
    for (int i = 0; i < MW; i++) begin
      vmask_nxt[i] = chain[SLOTS].b_seen[i] && (TW'(i) < chain[SLOTS].b_total);
    end
  end

  // bit count of one byte of the victim map
  always_comb begin
    chunk     = vmask_r[7:0];
    chunk_cnt = '0;
    for (int i = 0; i < 8; i++) begin
      chunk_cnt = chunk_cnt + TW'(chunk[i]);
    end
  end

  // entry update
  always_comb begin
    rp1 = 9'(rem_r) + 9'd1;
    t1  = cur_total_r;
    if ((fidx_r == 8'd0) && (9'(cur_total_r) < rp1)) begin
      t1 = rp1[TW-1:0];
    end
    t2 = t1;
    if (fidx_r >= 8'(t1)) begin
      t2 = TW'(fidx_r + 8'd1);
    end
    for (int i = 0; i < MW; i++) begin
      tmask[i] = (TW'(i) < t2);
    end
    seen_n   = cur_seen_r | (MW'(1) << fidx_r[5:0]);
    complete = ((seen_n & tmask) == tmask);
    end_byte = offset_r + 32'(plen_r);
    size_n   = (cur_size_r < end_byte) ? end_byte : cur_size_r;
  end

  assign slot_ext = 32'(slot_r);

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= frt_pkg::ST_IDLE;
      cnt_r         <= 8'd0;
      ictr_r        <= 16'd0;
      exp_r         <= 32'd0;
      miss_r        <= 32'd0;
      first_bytes_r <= 16'd1024;
      data_bytes_r  <= 16'd1024;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && ((in_mode == frt_pkg::MODE_STATS) || drop)) ||
                     (state_r == frt_pkg::ST_UPDATE);
      if (cfg_we) begin
        if (cfg_index == frt_pkg::CFG_FIRST_BYTES) begin
          first_bytes_r <= cfg_wdata;
        end else begin
          data_bytes_r <= cfg_wdata;
        end
      end
      if (state_nxt != state_r) begin
        cnt_r <= 8'd0;
      end else begin
        cnt_r <= cnt_r + 8'd1;
      end
      if (stats_acc) begin
        exp_r  <= 32'd0;
        miss_r <= 32'd0;
      end else if (state_r == frt_pkg::ST_UPDATE) begin
        exp_r  <= exp_r + (ev_r ? 32'(vt_r) : 32'd0) +
                  (complete ? 32'(t2) : 32'd0);
        miss_r <= miss_r + (ev_r ? 32'(vt_r - pc_r) : 32'd0);
      end
      if ((state_r == frt_pkg::ST_UPDATE) && new_r) begin
        ictr_r <= ictr_r + 16'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mid_r  <= in_message_id;
      fidx_r <= in_fragment_index;
      rem_r  <= in_remaining_fragments;
      plen_r <= in_payload_length;
    end
    case (state_r)
      frt_pkg::ST_RESOLVE: begin
        offset_r <= offset_nxt;
        pc_r     <= '0;
        vmask_r  <= vmask_nxt;
        vt_r     <= chain[SLOTS].b_total;
        if (chain[SLOTS].found) begin
          slot_r      <= chain[SLOTS].m_idx;
          new_r       <= 1'b0;
          ev_r        <= 1'b0;
          cur_seen_r  <= chain[SLOTS].m_seen;
          cur_total_r <= chain[SLOTS].m_total;
          cur_size_r  <= chain[SLOTS].m_size;
        end else begin
          slot_r      <= chain[SLOTS].have_free ? chain[SLOTS].f_idx : chain[SLOTS].b_idx;
          new_r       <= 1'b1;
          ev_r        <= !chain[SLOTS].have_free;
          cur_seen_r  <= '0;
          cur_total_r <= '0;
          cur_size_r  <= 32'd0;
        end
      end
      frt_pkg::ST_POP: begin
        pc_r    <= pc_r + chunk_cnt;
        vmask_r <= vmask_r >> 8;
      end
      default: begin
      end
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_out_r <= 5'd0;
      boff_r     <= 32'd0;
      msize_r    <= 32'd0;
      ftot_r     <= 7'd0;
      evo_r      <= 1'b0;
      ecnt_r     <= (in_mode == frt_pkg::MODE_STATS) ? exp_r : 32'd0;
      mcnt_r     <= (in_mode == frt_pkg::MODE_STATS) ? miss_r : 32'd0;
      status_r   <= (in_mode == frt_pkg::MODE_STATS) ? frt_pkg::STAT_STATS
                                                     : frt_pkg::STAT_DROP;
    end else if (state_r == frt_pkg::ST_UPDATE) begin
      status_r   <= complete ? frt_pkg::STAT_DONE : frt_pkg::STAT_ACCEPT;
      slot_out_r <= slot_ext[4:0];
      boff_r     <= offset_r;
      msize_r    <= size_n;
      ftot_r     <= t2;
      evo_r      <= ev_r;
      ecnt_r     <= 32'd0;
      mcnt_r     <= 32'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_slot_index     = slot_out_r;
  assign out_byte_offset    = boff_r;
  assign out_message_size   = msize_r;
  assign out_fragment_total = ftot_r;
  assign out_evicted        = evo_r;
  assign out_expected_count = ecnt_r;
  assign out_missing_count  = mcnt_r;

  // checks
  `FRT_ASSERT_SAME(a_strobe_idle, out_valid, !busy, "result strobe while busy")
  `FRT_ASSERT_NEXT(a_stats_next, start && !busy && (in_mode == frt_pkg::MODE_STATS),
    out_valid && (out_status == frt_pkg::STAT_STATS), "stats result not next cycle")
  `FRT_ASSERT_SAME(a_evict_status, out_valid && out_evicted,
    (out_status == frt_pkg::STAT_ACCEPT) || (out_status == frt_pkg::STAT_DONE),
    "eviction flagged on non fragment result")

endmodule

/* verif/testbench.sv */
// self-checking testbench of the fragment reassembly tracker
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_SLOTS  = 32;
  localparam int FRAG_LIMIT = 64;
  localparam int CYCLE_CAP  = 400000;

  typedef struct {
    logic        mode;
    logic [15:0] mid;
    logic [7:0]  fidx;
    logic [7:0]  remain;
    logic [15:0] plen;
  } frag_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [4:0]  slot;
    logic [31:0] offset;
    logic [31:0] size;
    logic [6:0]  total;
    logic        evicted;
    logic [31:0] exp_cnt;
    logic [31:0] miss_cnt;
  } frag_resp_t;

  // reassembly table model and queue of predicted responses
  class reassembly_board;
    bit          live[NUM_SLOTS];
    logic [15:0] owner[NUM_SLOTS];
    logic [63:0] seen[NUM_SLOTS];
    logic [6:0]  total[NUM_SLOTS];
    logic [31:0] size[NUM_SLOTS];
    logic [15:0] stamp[NUM_SLOTS];
    logic [15:0] ins_count;
    logic [31:0] exp_total;
    logic [31:0] miss_total;
    logic [15:0] first_bytes;
    logic [15:0] data_bytes;
    frag_resp_t  pending[$];
    int          errors;

    function new();
      for (int k = 0; k < NUM_SLOTS; k++) live[k] = 0;
      ins_count = 0;
      exp_total = 0;
      miss_total = 0;
      first_bytes = 16'd1024;
      data_bytes = 16'd1024;
      errors = 0;
    endfunction

    function logic [63:0] low_mask(int n);
      if (n >= 64) return '1;
      return (64'd1 << n) - 64'd1;
    endfunction

    // predict the response of one accepted transfer
    function void note_input(frag_req_t r);
      frag_resp_t e;
      int slot;
      bit found;
      bit free_seen;
      logic [15:0] age;
      logic [15:0] best;
      logic [31:0] end_byte;
      e = '{default: '0};
      slot = 0;
      found = 0;
      free_seen = 0;
      best = 0;
      if (r.mode == frt_pkg::MODE_STATS) begin
        e.status = frt_pkg::STAT_STATS;
        e.exp_cnt = exp_total;
        e.miss_cnt = miss_total;
        exp_total = 0;
        miss_total = 0;
      end else if (r.fidx >= FRAG_LIMIT || (r.fidx == 0 && r.remain + 1 > FRAG_LIMIT)) begin
        e.status = frt_pkg::STAT_DROP;
      end else begin
        for (int k = 0; k < NUM_SLOTS; k++)
          if (!found && live[k] && owner[k] == r.mid) begin
            slot = k;
            found = 1;
          end
        if (!found) begin
          for (int k = 0; k < NUM_SLOTS; k++)
            if (!free_seen && !live[k]) begin
              slot = k;
              free_seen = 1;
            end
          // table full: drop the oldest message
          if (!free_seen) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
              age = ins_count - stamp[k];
              if (k == 0 || age > best) begin
                best = age;
                slot = k;
              end
            end
            exp_total += total[slot];
            miss_total += total[slot] - $countones(seen[slot] & low_mask(total[slot]));
            e.evicted = 1;
          end
          live[slot] = 1;
          owner[slot] = r.mid;
          seen[slot] = 0;
          total[slot] = 0;
          size[slot] = 0;
          stamp[slot] = ins_count;
          ins_count++;
        end
        if (r.fidx == 0) begin
          e.offset = 0;
          if (total[slot] < r.remain + 1) total[slot] = r.remain + 1;
        end else begin
          e.offset = 32'(first_bytes) + 32'(r.fidx - 1) * 32'(data_bytes);
        end
        end_byte = e.offset + 32'(r.plen);
        if (size[slot] < end_byte) size[slot] = end_byte;
        if (r.fidx >= total[slot]) total[slot] = r.fidx + 1;
        seen[slot] |= 64'd1 << r.fidx;
        e.status = frt_pkg::STAT_ACCEPT;
        e.slot = slot[4:0];
        e.size = size[slot];
        e.total = total[slot];
        if ((seen[slot] & low_mask(total[slot])) == low_mask(total[slot])) begin
          e.status = frt_pkg::STAT_DONE;
          exp_total += total[slot];
          live[slot] = 0;
        end
      end
      pending = {pending, e};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    // compare one response with the oldest prediction
    task check_result(frag_resp_t g);
      frag_resp_t e;
      if (pending.size() == 0) begin
        report("unexpected response status", g.status, 0);
        return;
      end
      e = pending.pop_front();
      if (g.status !== e.status) report("status", g.status, e.status);
      if (g.slot !== e.slot) report("slot_index", g.slot, e.slot);
      if (g.offset !== e.offset) report("byte_offset", g.offset, e.offset);
      if (g.size !== e.size) report("message_size", g.size, e.size);
      if (g.total !== e.total) report("fragment_total", g.total, e.total);
      if (g.evicted !== e.evicted) report("evicted", g.evicted, e.evicted);
      if (g.exp_cnt !== e.exp_cnt) report("expected_count", g.exp_cnt, e.exp_cnt);
      if (g.miss_cnt !== e.miss_cnt) report("missing_count", g.miss_cnt, e.miss_cnt);
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic        cfg_index = frt_pkg::CFG_FIRST_BYTES;
  logic [15:0] cfg_wdata = 16'd0;
  logic        start = 0;
  logic        busy;
  logic        in_mode = frt_pkg::MODE_FRAG;
  logic [15:0] in_message_id = 16'd0;
  logic [7:0]  in_fragment_index = 8'd0;
  logic [7:0]  in_remaining_fragments = 8'd0;
  logic [15:0] in_payload_length = 16'd0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [4:0]  out_slot_index;
  logic [31:0] out_byte_offset;
  logic [31:0] out_message_size;
  logic [6:0]  out_fragment_total;
  logic        out_evicted;
  logic [31:0] out_expected_count;
  logic [31:0] out_missing_count;

  reassembly_board board = new();
  int cycles = 0;
  bit quiet = 0;
  logic [15:0] id_pool[48];

  fragment_reassembly_tracker #(.SLOTS(NUM_SLOTS), .MAX_FRAGS(FRAG_LIMIT)) u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .start(start), .busy(busy), .in_mode(in_mode),
    .in_message_id(in_message_id), .in_fragment_index(in_fragment_index),
    .in_remaining_fragments(in_remaining_fragments),
    .in_payload_length(in_payload_length), .out_valid(out_valid),
    .out_status(out_status), .out_slot_index(out_slot_index),
    .out_byte_offset(out_byte_offset), .out_message_size(out_message_size),
    .out_fragment_total(out_fragment_total), .out_evicted(out_evicted),
    .out_expected_count(out_expected_count), .out_missing_count(out_missing_count)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // input transfer monitor
  always @(posedge clk)
    if (rst_n && start && !busy)
      board.note_input('{in_mode, in_message_id, in_fragment_index,
                         in_remaining_fragments, in_payload_length});

  // response monitor
  always @(posedge clk)
    if (rst_n && out_valid)
      board.check_result('{out_status, out_slot_index, out_byte_offset, out_message_size,
                           out_fragment_total, out_evicted, out_expected_count,
                           out_missing_count});

  // present one item and hold it until the transfer
  task send(logic mode, logic [15:0] mid, logic [7:0] fidx, logic [7:0] remain,
            logic [15:0] plen);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 26) begin
      start = 0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_mode = mode;
    in_message_id = mid;
    in_fragment_index = fidx;
    in_remaining_fragments = remain;
    in_payload_length = plen;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task drain();
    @(negedge clk);
    start = 0;
    while (board.pending.size() != 0 || busy) @(negedge clk);
  endtask

  task write_reg(logic idx, logic [15:0] val);
    drain();
    cfg_we = 1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == frt_pkg::CFG_FIRST_BYTES) board.first_bytes = val;
    else board.data_bytes = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // mostly small messages from a shared id pool, some drops and stats reads
  task random_item();
    int pick;
    logic [15:0] mid;
    pick = $urandom_range(0, 99);
    mid = id_pool[$urandom_range(0, 47)];
    if (pick < 4)
      send(frt_pkg::MODE_STATS, 16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    else if (pick < 8)
      send(frt_pkg::MODE_FRAG, mid, 8'($urandom_range(64, 255)), 8'($urandom),
           16'($urandom));
    else if (pick < 11)
      send(frt_pkg::MODE_FRAG, mid, 8'd0, 8'($urandom_range(64, 255)), 16'($urandom));
    else if (pick < 50)
      send(frt_pkg::MODE_FRAG, mid, 8'd0,
           (pick < 14) ? 8'($urandom_range(0, 63)) : 8'($urandom_range(0, 3)),
           16'($urandom));
    else
      send(frt_pkg::MODE_FRAG, mid,
           (pick < 54) ? 8'($urandom_range(1, 63)) : 8'($urandom_range(1, 4)),
           8'($urandom), 16'($urandom));
  endtask

  task random_phase(int count);
    for (int n = 0; n < count; n++) begin
      quiet = (n >= count / 3 && n < count / 2);
      random_item();
    end
    quiet = 0;
  endtask

  initial begin
    for (int k = 0; k < 48; k++) id_pool[k] = 16'($urandom);
    repeat (6) @(negedge clk);
    rst_n = 1;

    // directed: counters empty, extremes, drops, out-of-order arrival
    send(frt_pkg::MODE_STATS, 16'd0, 8'd0, 8'd0, 16'd0);
    send(frt_pkg::MODE_FRAG, 16'h0000, 8'd0, 8'd0, 16'h0000);
    send(frt_pkg::MODE_FRAG, 16'hFFFF, 8'd0, 8'd63, 16'hFFFF);
    send(frt_pkg::MODE_FRAG, 16'hFFFF, 8'd63, 8'd0, 16'hFFFF);
    send(frt_pkg::MODE_FRAG, 16'h1234, 8'd64, 8'd0, 16'h0001);
    send(frt_pkg::MODE_FRAG, 16'h1234, 8'd255, 8'd255, 16'hFFFF);
    send(frt_pkg::MODE_FRAG, 16'h1234, 8'd0, 8'd64, 16'h0010);
    send(frt_pkg::MODE_FRAG, 16'h1234, 8'd0, 8'd255, 16'h0010);
    send(frt_pkg::MODE_FRAG, 16'h5555, 8'd5, 8'd0, 16'h0100);
    send(frt_pkg::MODE_FRAG, 16'h5555, 8'd0, 8'd2, 16'h0200);
    send(frt_pkg::MODE_FRAG, 16'h5555, 8'd2, 8'd0, 16'h0300);
    send(frt_pkg::MODE_FRAG, 16'h5555, 8'd1, 8'd0, 16'h0400);
    send(frt_pkg::MODE_FRAG, 16'hAAAA, 8'd1, 8'd0, 16'h0000);
    send(frt_pkg::MODE_FRAG, 16'hAAAA, 8'd1, 8'd0, 16'hFFFF);
    send(frt_pkg::MODE_FRAG, 16'hAAAA, 8'd0, 8'd1, 16'h0001);
    send(frt_pkg::MODE_STATS, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);

    random_phase(200);
    write_reg(frt_pkg::CFG_FIRST_BYTES, 16'd1);
    write_reg(frt_pkg::CFG_DATA_BYTES, 16'd1);
    random_phase(200);
    write_reg(frt_pkg::CFG_FIRST_BYTES, 16'hFFFF);
    write_reg(frt_pkg::CFG_DATA_BYTES, 16'hFFFF);
    send(frt_pkg::MODE_FRAG, 16'hBEEF, 8'd63, 8'd0, 16'hFFFF);
    random_phase(200);
    write_reg(frt_pkg::CFG_FIRST_BYTES, 16'($urandom_range(1, 65535)));
    write_reg(frt_pkg::CFG_DATA_BYTES, 16'($urandom_range(1, 65535)));
    random_phase(200);
    send(frt_pkg::MODE_STATS, 16'd0, 8'd0, 8'd0, 16'd0);

    drain();
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
